// ===== design/apt_pkg.sv =====
package apt_pkg;

   localparam int TIME_BITS_DEFAULT = 16;
   localparam int TIME_BITS_MIN     = 12;
   localparam int TIME_BITS_MAX     = 32;

   localparam int CMD_W    = 2;
   localparam int MODE_W   = 2;
   localparam int STAMP_W  = 16;
   localparam int DELAY_W  = 15;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [DELAY_W-1:0] ON_TIME_RESET   = 15'd7200;
   localparam logic [DELAY_W-1:0] IGN_DELAY_RESET = 15'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_SHORT = 2'd1,
      CMD_LONG  = 2'd2,
      CMD_IGN   = 2'd3
   } cmd_type;

   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IGN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TMR = 2'd2;

   typedef enum logic [2:0] {
      ST_OFF = 3'b001,
      ST_IGN = 3'b010,
      ST_TMR = 3'b100
   } pmode_type;

   typedef enum logic {
      REG_ON_TIME   = 1'b0,
      REG_IGN_DELAY = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic                power_out;
      logic [MODE_W-1:0]   mode;
      logic                expired;
      logic [STAMP_W-1:0]  remaining;
   } result_type;

   function automatic logic [MODE_W-1:0] mode_code(input pmode_type st);
      logic [MODE_W-1:0] code;
      code = MODE_OFF;
      unique case (st)
         ST_OFF: code = MODE_OFF;
         ST_IGN: code = MODE_IGN;
         ST_TMR: code = MODE_TMR;
         default: code = MODE_OFF;
      endcase
      return code;
   endfunction

endpackage

// ===== design/apt_req_if.sv =====
interface apt_req_if;
   logic                             valid;
   logic                             ready;
   logic [apt_pkg::CMD_W-1:0]        command;
   logic                             ignition_level;
   logic [apt_pkg::STAMP_W-1:0]      now_time;

   modport source (output valid, command, ignition_level, now_time, input ready);
   modport sink   (input valid, command, ignition_level, now_time, output ready);
endinterface

// ===== design/apt_rsp_if.sv =====
interface apt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             power_out;
   logic [apt_pkg::MODE_W-1:0]       mode;
   logic                             expired;
   logic [apt_pkg::STAMP_W-1:0]      remaining;

   modport source (output valid, power_out, mode, expired, remaining, input ready);
   modport sink   (input valid, power_out, mode, expired, remaining, output ready);
endinterface

// ===== design/apt_step.sv =====
module apt_step #(
   parameter int TIME_BITS = apt_pkg::TIME_BITS_DEFAULT
) (
   input  apt_pkg::cmd_type                 command,
   input  logic                             ignition_level,
   input  logic [apt_pkg::STAMP_W-1:0]      now_time,
   input  logic [apt_pkg::DELAY_W-1:0]      on_time,
   input  logic [apt_pkg::DELAY_W-1:0]      ign_delay,
   input  apt_pkg::pmode_type               mode_cur,
   input  logic [TIME_BITS-1:0]             deadline_cur,
   output apt_pkg::pmode_type               mode_nxt,
   output logic [TIME_BITS-1:0]             deadline_nxt,
   output apt_pkg::result_type              result
);

   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] diff;
   logic [TIME_BITS-1:0] remain;
   logic                 expired;

   assign now    = TIME_BITS'(now_time);
   assign diff   = now - deadline_cur;
   assign remain = deadline_nxt - now;

   always_comb begin
      mode_nxt     = mode_cur;
      deadline_nxt = deadline_cur;
      expired      = 1'b0;
      case (command)
         apt_pkg::CMD_TICK: begin
            if (mode_cur == apt_pkg::ST_TMR && !diff[TIME_BITS-1]) begin
               mode_nxt = apt_pkg::ST_OFF;
               expired  = 1'b1;
            end
         end
         apt_pkg::CMD_SHORT: begin
            if (mode_cur != apt_pkg::ST_OFF) begin
               mode_nxt = apt_pkg::ST_OFF;
            end else if (ignition_level) begin
               mode_nxt = apt_pkg::ST_IGN;
            end else begin
               mode_nxt     = apt_pkg::ST_TMR;
               deadline_nxt = now + TIME_BITS'(on_time);
            end
         end
         apt_pkg::CMD_LONG: begin
            if (mode_cur == apt_pkg::ST_TMR) begin
               deadline_nxt = now + TIME_BITS'(on_time);
            end
         end
         default: begin
            if (ignition_level) begin
               mode_nxt = apt_pkg::ST_IGN;
            end else if (mode_cur == apt_pkg::ST_IGN) begin
               if (ign_delay != '0) begin
                  mode_nxt     = apt_pkg::ST_TMR;
                  deadline_nxt = now + TIME_BITS'(ign_delay);
               end else begin
                  mode_nxt = apt_pkg::ST_OFF;
               end
            end
         end
      endcase
   end

   always_comb begin
      result.power_out = (mode_nxt != apt_pkg::ST_OFF);
      result.mode      = apt_pkg::mode_code(mode_nxt);
      result.expired   = expired;
      result.remaining = (mode_nxt == apt_pkg::ST_TMR)
                         ? apt_pkg::STAMP_W'(remain) : '0;
   end

endmodule

// ===== design/accessory_power_timer.sv =====
// Channel  Dir  Handshake      Word
// req_if   in   valid/ready    command, ignition_level, now_time
// rsp_if   out  valid/ready    power_out, mode, expired, remaining
// csr      in   APB, pready=1  on_time @0x0, ignition_off_delay @0x4
//
// One word per cycle sustained while rsp is not stalled; an accepted word moves from the
// input register to the result register, where rsp valid presents it.
// The mode/deadline update is a single combinational pass between the two registers.
// Synchronous active-high reset: mode off, deadline 0, registers to defaults.
// A stalled rsp holds the result register; the input register takes a word while it is
// empty or moving on; with both registers full and rsp stalled, req ready drops.
module accessory_power_timer #(
   parameter int TIME_BITS = apt_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   apt_req_if.sink                       req_if,
   apt_rsp_if.source                     rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [apt_pkg::CSR_AW-1:0]    paddr,
   input  logic [apt_pkg::CSR_DW-1:0]    pwdata,
   output logic [apt_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   logic [apt_pkg::DELAY_W-1:0]  on_time_ff, on_time_in;
   logic [apt_pkg::DELAY_W-1:0]  ign_delay_ff, ign_delay_in;
   apt_pkg::pmode_type           mode_ff, mode_in;
   logic [TIME_BITS-1:0]         deadline_ff, deadline_in;

   logic                         s1_valid_ff, s1_valid_in;
   apt_pkg::cmd_type             s1_cmd_ff;
   logic                         s1_ign_ff;
   logic [apt_pkg::STAMP_W-1:0]  s1_now_ff;

   logic                         out_valid_ff, out_valid_in;
   apt_pkg::result_type          out_ff;

   apt_pkg::pmode_type           step_mode;
   logic [TIME_BITS-1:0]         step_deadline;
   apt_pkg::result_type          step_result;

   logic                         advance;
   logic                         req_take;
   logic                         csr_write;
   apt_pkg::reg_idx_type         csr_idx;

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = apt_pkg::reg_idx_type'(paddr[2]);

   always_comb begin
      on_time_in   = on_time_ff;
      ign_delay_in = ign_delay_ff;
      if (csr_write) begin
         unique case (csr_idx)
            apt_pkg::REG_ON_TIME:   on_time_in   = pwdata[apt_pkg::DELAY_W-1:0];
            apt_pkg::REG_IGN_DELAY: ign_delay_in = pwdata[apt_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         apt_pkg::REG_ON_TIME:   prdata = apt_pkg::CSR_DW'(on_time_ff);
         apt_pkg::REG_IGN_DELAY: prdata = apt_pkg::CSR_DW'(ign_delay_ff);
         default: prdata = '0;
      endcase
   end

   // pipeline control
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;
   assign s1_valid_in   = req_take || (s1_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_if.ready);

   apt_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .command        (s1_cmd_ff),
      .ignition_level (s1_ign_ff),
      .now_time       (s1_now_ff),
      .on_time        (on_time_ff),
      .ign_delay      (ign_delay_ff),
      .mode_cur       (mode_ff),
      .deadline_cur   (deadline_ff),
      .mode_nxt       (step_mode),
      .deadline_nxt   (step_deadline),
      .result         (step_result)
   );

   assign mode_in     = advance ? step_mode     : mode_ff;
   assign deadline_in = advance ? step_deadline : deadline_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff   <= apt_pkg::ON_TIME_RESET;
         ign_delay_ff <= apt_pkg::IGN_DELAY_RESET;
         mode_ff      <= apt_pkg::ST_OFF;
         deadline_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         on_time_ff   <= on_time_in;
         ign_delay_ff <= ign_delay_in;
         mode_ff      <= mode_in;
         deadline_ff  <= deadline_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff <= apt_pkg::cmd_type'(req_if.command);
         s1_ign_ff <= req_if.ignition_level;
         s1_now_ff <= req_if.now_time;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.power_out = out_ff.power_out;
   assign rsp_if.mode      = out_ff.mode;
   assign rsp_if.expired   = out_ff.expired;
   assign rsp_if.remaining = out_ff.remaining;

   // checks
   a_expired_off: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.expired |-> rsp_if.mode == apt_pkg::MODE_OFF)
      else $error("expired word with output still on");

   a_power_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.power_out == (rsp_if.mode != apt_pkg::MODE_OFF))
      else $error("power_out disagrees with mode");

   a_remaining_tmr: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.remaining != '0 |-> rsp_if.mode == apt_pkg::MODE_TMR)
      else $error("remaining time without timer");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(deadline_ff))
      else $error("state changed without a word");

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;

   class power_scoreboard;
      logic [apt_pkg::MODE_W-1:0]  mode;
      logic [apt_pkg::STAMP_W-1:0] deadline;
      logic [apt_pkg::DELAY_W-1:0] on_time;
      logic [apt_pkg::DELAY_W-1:0] ign_delay;
      apt_pkg::result_type         pending_results[$];
      int                          errors;
      int                          checked;
      int                          expiries;

      function new();
         mode      = apt_pkg::MODE_OFF;
         deadline  = '0;
         on_time   = apt_pkg::ON_TIME_RESET;
         ign_delay = apt_pkg::IGN_DELAY_RESET;
         errors    = 0;
         checked   = 0;
         expiries  = 0;
      endfunction

      function void set_reg(apt_pkg::reg_idx_type idx, logic [apt_pkg::DELAY_W-1:0] value);
         if (idx == apt_pkg::REG_ON_TIME) begin
            on_time = value;
         end else begin
            ign_delay = value;
         end
      endfunction

      function void note_request(apt_pkg::cmd_type cmd, logic lvl,
                                 logic [apt_pkg::STAMP_W-1:0] stamp);
         apt_pkg::result_type         res;
         logic [apt_pkg::STAMP_W-1:0] diff;
         logic                        ran_out;
         ran_out = 1'b0;
         case (cmd)
            apt_pkg::CMD_TICK: begin
               if (mode == apt_pkg::MODE_TMR) begin
                  diff = stamp - deadline;
                  if (!diff[apt_pkg::STAMP_W-1]) begin
                     mode    = apt_pkg::MODE_OFF;
                     ran_out = 1'b1;
                  end
               end
            end
            apt_pkg::CMD_SHORT: begin
               if (mode != apt_pkg::MODE_OFF) begin
                  mode = apt_pkg::MODE_OFF;
               end else if (lvl) begin
                  mode = apt_pkg::MODE_IGN;
               end else begin
                  deadline = stamp + {1'b0, on_time};
                  mode     = apt_pkg::MODE_TMR;
               end
            end
            apt_pkg::CMD_LONG: begin
               if (mode == apt_pkg::MODE_TMR) begin
                  deadline = stamp + {1'b0, on_time};
               end
            end
            default: begin
               if (lvl) begin
                  mode = apt_pkg::MODE_IGN;
               end else if (mode == apt_pkg::MODE_IGN) begin
                  if (ign_delay != '0) begin
                     deadline = stamp + {1'b0, ign_delay};
                     mode     = apt_pkg::MODE_TMR;
                  end else begin
                     mode = apt_pkg::MODE_OFF;
                  end
               end
            end
         endcase
         res.power_out = (mode != apt_pkg::MODE_OFF);
         res.mode      = mode;
         res.expired   = ran_out;
         res.remaining = (mode == apt_pkg::MODE_TMR) ? deadline - stamp : '0;
         pending_results.push_back(res);
      endfunction

      function void check_result(apt_pkg::result_type got);
         apt_pkg::result_type want;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: mode %0d remaining %0d",
                   got.mode, got.remaining);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.expired === 1'b1) expiries++;
         if (got.power_out !== want.power_out) begin
            $error("power_out expected %0d got %0d", want.power_out, got.power_out);
            errors++;
         end
         if (got.mode !== want.mode) begin
            $error("mode expected %0d got %0d", want.mode, got.mode);
            errors++;
         end
         if (got.expired !== want.expired) begin
            $error("expired expected %0d got %0d", want.expired, got.expired);
            errors++;
         end
         if (got.remaining !== want.remaining) begin
            $error("remaining expected %0d got %0d", want.remaining, got.remaining);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [apt_pkg::CSR_AW-1:0]  paddr;
   logic [apt_pkg::CSR_DW-1:0]  pwdata;
   logic [apt_pkg::CSR_DW-1:0]  prdata;
   logic                        pready;

   apt_req_if req ();
   apt_rsp_if rsp ();

   accessory_power_timer dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req),
      .rsp_if  (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   power_scoreboard             board = new();
   int                          words_sent;
   int                          settings_used;
   int                          burst_left;
   int                          idle_cycles;
   int                          rx_cycle;
   logic                        ign_line;
   logic [apt_pkg::STAMP_W-1:0] stamp;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // receiver: check, then choose the next ready from a rotating stall pattern
   always @(posedge clock) begin : rx
      apt_pkg::result_type got;
      if (!reset && rsp.valid === 1'b1 && rsp.ready) begin
         got.power_out = rsp.power_out;
         got.mode      = rsp.mode;
         got.expired   = rsp.expired;
         got.remaining = rsp.remaining;
         board.check_result(got);
      end
      rx_cycle++;
      case ((rx_cycle / 300) % 4)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 9) < 7);
         2: rsp.ready <= ($urandom_range(0, 9) < 2);
         default: rsp.ready <= (rx_cycle % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input apt_pkg::cmd_type cmd, input logic lvl,
                            input logic [apt_pkg::STAMP_W-1:0] t);
      req.valid          <= 1'b1;
      req.command        <= cmd;
      req.ignition_level <= lvl;
      req.now_time       <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(cmd, lvl, t);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(0, 30);
      end
   endtask

   task automatic write_reg(input apt_pkg::reg_idx_type idx,
                            input logic [apt_pkg::DELAY_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= apt_pkg::CSR_AW'(4 * int'(idx));
      pwdata  <= apt_pkg::CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [apt_pkg::DELAY_W-1:0] on_val,
                                 input logic [apt_pkg::DELAY_W-1:0] delay_val);
      drain();
      write_reg(apt_pkg::REG_ON_TIME, on_val);
      write_reg(apt_pkg::REG_IGN_DELAY, delay_val);
      settings_used++;
   endtask

   // mostly advancing time with ticks aimed around the deadline, some jumps
   task automatic run_random(input int count);
      apt_pkg::cmd_type cmd;
      logic             lvl;
      int               pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      cmd = apt_pkg::CMD_TICK;
         else if (pick < 65) cmd = apt_pkg::CMD_SHORT;
         else if (pick < 78) cmd = apt_pkg::CMD_LONG;
         else                cmd = apt_pkg::CMD_IGN;
         if (cmd == apt_pkg::CMD_IGN && $urandom_range(0, 3) != 0) ign_line = ~ign_line;
         lvl = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : ign_line;
         stamp = stamp + apt_pkg::STAMP_W'($urandom_range(0, 6));
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            stamp = apt_pkg::STAMP_W'($urandom);
         end else if (cmd == apt_pkg::CMD_TICK && board.mode == apt_pkg::MODE_TMR
                      && pick < 45) begin
            case ($urandom_range(0, 3))
               0, 1: stamp = board.deadline + apt_pkg::STAMP_W'($urandom_range(0, 4))
                             - 16'd2;
               2: stamp = board.deadline + 16'h7FFF;
               default: stamp = board.deadline + 16'h8000;
            endcase
         end
         send_word(cmd, lvl, stamp);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      req.valid   <= 1'b0;
      req.command <= apt_pkg::CMD_TICK;
      req.ignition_level <= 1'b0;
      req.now_time       <= '0;
      words_sent    = 0;
      settings_used = 0;
      burst_left    = 8;
      ign_line      = 1'b0;
      stamp         = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: idle commands, timer, restart, expiry, ignition mode
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'd0);
      send_word(apt_pkg::CMD_LONG,  1'b0, 16'd10);
      send_word(apt_pkg::CMD_IGN,   1'b0, 16'd20);
      send_word(apt_pkg::CMD_SHORT, 1'b0, 16'd100);
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'd7299);
      send_word(apt_pkg::CMD_LONG,  1'b0, 16'd200);
      send_word(apt_pkg::CMD_IGN,   1'b0, 16'd300);
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'd7400);
      send_word(apt_pkg::CMD_SHORT, 1'b1, 16'hFFFF);
      send_word(apt_pkg::CMD_IGN,   1'b1, 16'd5);
      send_word(apt_pkg::CMD_LONG,  1'b1, 16'd6);
      send_word(apt_pkg::CMD_TICK,  1'b1, 16'd7);
      send_word(apt_pkg::CMD_IGN,   1'b0, 16'd8);
      send_word(apt_pkg::CMD_IGN,   1'b1, 16'd9);
      send_word(apt_pkg::CMD_SHORT, 1'b1, 16'd10);

      // zero on-time, longest ignition delay, wrap of the deadline compare
      apply_settings(15'd0, 15'h7FFF);
      send_word(apt_pkg::CMD_IGN,   1'b1, 16'd5);
      send_word(apt_pkg::CMD_IGN,   1'b0, 16'hFFF0);
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'h7FEE);
      send_word(apt_pkg::CMD_IGN,   1'b1, 16'h7FF0);
      send_word(apt_pkg::CMD_SHORT, 1'b1, 16'h7FF1);
      send_word(apt_pkg::CMD_SHORT, 1'b0, 16'h1234);
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'h9234);
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'h9233);
      send_word(apt_pkg::CMD_SHORT, 1'b0, 16'h0000);
      send_word(apt_pkg::CMD_TICK,  1'b0, 16'h0000);

      apply_settings(15'h7FFF, 15'd0);
      run_random(250);
      apply_settings(15'd1, 15'd1);
      run_random(250);
      apply_settings(apt_pkg::DELAY_W'($urandom_range(0, 24)),
                     apt_pkg::DELAY_W'($urandom_range(1, 24)));
      run_random(250);
      apply_settings(apt_pkg::DELAY_W'($urandom_range(0, 32767)),
                     apt_pkg::DELAY_W'($urandom_range(0, 32767)));
      run_random(250);
      apply_settings(15'd7200, 15'd3);
      run_random(250);
      apply_settings(apt_pkg::DELAY_W'($urandom_range(0, 32767)), 15'd0);
      run_random(250);
      drain();

      $display("%0d request words sent over %0d register settings", words_sent,
               settings_used + 1);
      $display("%0d result words checked, %0d timer expiries seen", board.checked,
               board.expiries);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
